FILE: rtl/core/scs_pkg.sv
// shared types and constants of the sine and cosine series block
package scs_pkg;

  localparam int X_W      = 34;
  localparam int X2_W     = 36;
  localparam int T_W      = 35;
  localparam int V_W      = 38;
  localparam int Q_W      = 38;
  localparam int SUM_W    = 38;
  localparam int RECIP_SH = 38;
  localparam int DIV_W    = 11;
  localparam int REM_STEPS = 13;

  localparam logic [63:0] TWO_PI_Q48 = 64'h0006_487E_D511_0B46;
  localparam logic [63:0] PI_Q48     = 64'h0003_243F_6A88_85A3;
  localparam logic [63:0] ROUND_Q16  = 64'h0000_0000_0000_8000;
  localparam logic [T_W-1:0]   ONE_Q32 = T_W'(64'h1_0000_0000);
  localparam logic [SUM_W-1:0] ONE_Q30 = SUM_W'(64'h4000_0000);

  typedef struct packed {
    logic           neg;
    logic [X_W-1:0] x;
  } mid_t;

  typedef struct packed {
    logic [31:0] sine;
    logic [31:0] cosine;
  } res_t;

endpackage

FILE: rtl/core/scs_queue.sv
// small register queue between pipeline parts
module scs_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  output logic         full,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic         empty,
  output logic [W-1:0] dout
);

  localparam int AW = $clog2(DEPTH);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [AW:0]   count_r;
  logic          do_push, do_pop;

  assign full    = (count_r == (AW+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop) count_r <= count_r + 1'b1;
      else if (!do_push && do_pop) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= din;
  end

endmodule

FILE: rtl/core/scs_front.sv
// angle range reduction and folding pipeline
module scs_front (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [31:0] in_angle,
  output logic        out_push,
  input  logic        out_full,
  output scs_pkg::mid_t out_data
);

  localparam int LAST = scs_pkg::REM_STEPS + 1;

  logic [63:0]   r_r   [scs_pkg::REM_STEPS+1];
  logic          neg_r [scs_pkg::REM_STEPS+1];
  logic          vld_r [LAST+1];
  scs_pkg::mid_t res_r;
  logic          ce;
  logic [31:0]   mag;
  logic [63:0]   rf, rnd;
  logic          nf;

  assign ce       = !vld_r[LAST] || !out_full;
  assign in_full  = !ce;
  assign out_push = vld_r[LAST] && !out_full;
  assign out_data = res_r;
  assign mag      = in_angle[31] ? 32'(32'd0 - in_angle) : in_angle;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= LAST; i++) vld_r[i] <= 1'b0;
    end else if (ce) begin
      vld_r[0] <= in_push;
      for (int i = 1; i <= LAST; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      r_r[0]   <= {mag, 32'd0};
      neg_r[0] <= in_angle[31];
    end
  end

  for (genvar j = 1; j <= scs_pkg::REM_STEPS; j++) begin : g_rem
    localparam logic [63:0] DS = scs_pkg::TWO_PI_Q48 << (scs_pkg::REM_STEPS - j);
    always_ff @(posedge clk) begin
      if (ce) begin
        r_r[j]   <= (r_r[j-1] >= DS) ? r_r[j-1] - DS : r_r[j-1];
        neg_r[j] <= neg_r[j-1];
      end
    end
  end

  // fold into (-pi, pi], then round to q32
  always_comb begin
    rf = r_r[scs_pkg::REM_STEPS];
    nf = neg_r[scs_pkg::REM_STEPS];
    if (!nf) begin
      if (rf > scs_pkg::PI_Q48) begin
        rf = scs_pkg::TWO_PI_Q48 - rf;
        nf = 1'b1;
      end
    end else begin
      if (rf >= scs_pkg::PI_Q48) begin
        rf = scs_pkg::TWO_PI_Q48 - rf;
        nf = 1'b0;
      end
    end
    rnd = rf + scs_pkg::ROUND_Q16;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      res_r.neg <= nf;
      res_r.x   <= rnd[scs_pkg::X_W+15:16];
    end
  end

endmodule

FILE: rtl/core/scs_series.sv
// series evaluation pipeline, one term per three stages
module scs_series #(
  parameter int TERMS = 12
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_empty,
  output logic          in_pop,
  input  scs_pkg::mid_t in_data,
  output logic          out_push,
  input  logic          out_full,
  output scs_pkg::res_t out_data
);

  localparam int NST = 3 * (TERMS - 1) + 1;

  typedef struct packed {
    logic                              neg;
    logic [scs_pkg::X2_W-1:0]          x2;
    logic [scs_pkg::T_W-1:0]           s_t;
    logic [scs_pkg::T_W-1:0]           c_t;
    logic signed [scs_pkg::SUM_W-1:0]  s_sum;
    logic signed [scs_pkg::SUM_W-1:0]  c_sum;
    logic [scs_pkg::V_W-1:0]           s_v;
    logic [scs_pkg::V_W-1:0]           c_v;
    logic [scs_pkg::Q_W-1:0]           s_q;
    logic [scs_pkg::Q_W-1:0]           c_q;
  } lane_t;

  function automatic logic [31:0] to_q30(input logic signed [scs_pkg::SUM_W-1:0] s);
    logic [scs_pkg::SUM_W-1:0] mag;
    logic [scs_pkg::SUM_W-1:0] m;
    mag = s[scs_pkg::SUM_W-1] ? scs_pkg::SUM_W'(-s) : scs_pkg::SUM_W'(s);
    m   = (mag + scs_pkg::SUM_W'(2)) >> 2;
    if (m > scs_pkg::ONE_Q30) m = scs_pkg::ONE_Q30;
    return s[scs_pkg::SUM_W-1] ? 32'(32'd0 - m[31:0]) : m[31:0];
  endfunction

  lane_t         lane_r [NST];
  logic          vld_r  [NST+1];
  scs_pkg::res_t res_r;
  logic          ce;
  logic [2*scs_pkg::X_W-1:0] xx;
  logic signed [scs_pkg::SUM_W-1:0] s_fin;

  assign ce       = !vld_r[NST] || !out_full;
  assign in_pop   = ce && !in_empty;
  assign out_push = vld_r[NST] && !out_full;
  assign out_data = res_r;
  assign xx       = in_data.x * in_data.x;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= NST; i++) vld_r[i] <= 1'b0;
    end else if (ce) begin
      vld_r[0] <= !in_empty;
      for (int i = 1; i <= NST; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      lane_r[0].neg   <= in_data.neg;
      lane_r[0].x2    <= xx[scs_pkg::X2_W+31:32];
      lane_r[0].s_t   <= scs_pkg::T_W'(in_data.x);
      lane_r[0].c_t   <= scs_pkg::ONE_Q32;
      lane_r[0].s_sum <= $signed(scs_pkg::SUM_W'(in_data.x));
      lane_r[0].c_sum <= $signed(scs_pkg::SUM_W'(scs_pkg::ONE_Q32));
      lane_r[0].s_v   <= '0;
      lane_r[0].c_v   <= '0;
      lane_r[0].s_q   <= '0;
      lane_r[0].c_q   <= '0;
    end
  end

  for (genvar k = 1; k < TERMS; k++) begin : g_term
    localparam int IA = 3 * k - 2;
    localparam int IB = 3 * k - 1;
    localparam int IC = 3 * k;
    localparam int SDIV = (2 * k + 1) * (2 * k);
    localparam int CDIV = (2 * k) * (2 * k - 1);
    localparam logic [scs_pkg::V_W-1:0] SREC = scs_pkg::V_W'((64'd1 << scs_pkg::RECIP_SH) / SDIV);
    localparam logic [scs_pkg::V_W-1:0] CREC = scs_pkg::V_W'((64'd1 << scs_pkg::RECIP_SH) / CDIV);
    localparam logic [scs_pkg::DIV_W-1:0] SD = scs_pkg::DIV_W'(SDIV);
    localparam logic [scs_pkg::DIV_W-1:0] CD = scs_pkg::DIV_W'(CDIV);

    lane_t a_nxt, b_nxt, c_nxt;
    logic [scs_pkg::T_W+scs_pkg::X2_W-1:0] sp, cp;
    logic [scs_pkg::V_W+scs_pkg::V_W-1:0]  sr, cr;
    logic [scs_pkg::Q_W+scs_pkg::DIV_W-1:0] sm, cm;
    logic [scs_pkg::V_W-1:0] srem, crem;
    logic [scs_pkg::T_W-1:0] st, ct;

    // term times x squared, back to q32
    always_comb begin
      a_nxt     = lane_r[IA-1];
      sp        = lane_r[IA-1].s_t * lane_r[IA-1].x2;
      cp        = lane_r[IA-1].c_t * lane_r[IA-1].x2;
      a_nxt.s_v = sp[scs_pkg::V_W+31:32];
      a_nxt.c_v = cp[scs_pkg::V_W+31:32];
    end

    // quotient estimate by reciprocal
    always_comb begin
      b_nxt     = lane_r[IB-1];
      sr        = lane_r[IB-1].s_v * SREC;
      cr        = lane_r[IB-1].c_v * CREC;
      b_nxt.s_q = sr[scs_pkg::RECIP_SH+scs_pkg::Q_W-1:scs_pkg::RECIP_SH];
      b_nxt.c_q = cr[scs_pkg::RECIP_SH+scs_pkg::Q_W-1:scs_pkg::RECIP_SH];
    end

    // one correction step, then accumulate with alternating sign
    always_comb begin
      c_nxt = lane_r[IC-1];
      sm    = lane_r[IC-1].s_q * SD;
      cm    = lane_r[IC-1].c_q * CD;
      srem  = lane_r[IC-1].s_v - sm[scs_pkg::V_W-1:0];
      crem  = lane_r[IC-1].c_v - cm[scs_pkg::V_W-1:0];
      st    = scs_pkg::T_W'(lane_r[IC-1].s_q) + scs_pkg::T_W'(srem >= scs_pkg::V_W'(SD));
      ct    = scs_pkg::T_W'(lane_r[IC-1].c_q) + scs_pkg::T_W'(crem >= scs_pkg::V_W'(CD));
      c_nxt.s_t = st;
      c_nxt.c_t = ct;
      if (k % 2 == 1) begin
        c_nxt.s_sum = lane_r[IC-1].s_sum - $signed(scs_pkg::SUM_W'(st));
        c_nxt.c_sum = lane_r[IC-1].c_sum - $signed(scs_pkg::SUM_W'(ct));
      end else begin
        c_nxt.s_sum = lane_r[IC-1].s_sum + $signed(scs_pkg::SUM_W'(st));
        c_nxt.c_sum = lane_r[IC-1].c_sum + $signed(scs_pkg::SUM_W'(ct));
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        lane_r[IA] <= a_nxt;
        lane_r[IB] <= b_nxt;
        lane_r[IC] <= c_nxt;
      end
    end
  end

  assign s_fin = lane_r[NST-1].neg ? -lane_r[NST-1].s_sum : lane_r[NST-1].s_sum;

  always_ff @(posedge clk) begin
    if (ce) begin
      res_r.sine   <= to_q30(s_fin);
      res_r.cosine <= to_q30(lane_r[NST-1].c_sum);
    end
  end

endmodule

FILE: rtl/core/sine_cosine_series.sv
// top level of the sine and cosine series block
//
// input queue side: present in_angle (signed q16.16 radians) with in_push;
// a transfer happens on a rising edge with in_push high and in_full low.
// result queue side: out_sine and out_cosine (signed q2.30, saturated to
// plus or minus one) hold the oldest result while out_empty is low; a
// transfer happens on a rising edge with out_pop high and out_empty low.
// without stalls, one angle per cycle is taken and one result per cycle
// delivered. from input transfer to visible result an angle passes the
// range reduction stages (an input stage, 13 quotient bits, the fold),
// one middle queue stage, one series entry stage, three stages per further
// series term (multiply, reciprocal estimate, correction) for sine and
// cosine side by side, one output stage and one result queue stage.
// a four entry queue parts range reduction from the series pipeline, so
// each half stalls on its own; when the receiver stalls the result queue
// fills, the series pipeline halts, then the middle queue, then in_full
// rises. reset empties both queues and clears all stage valid flags.
module sine_cosine_series #(
  parameter int SERIES_TERMS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [31:0] in_angle,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [31:0] out_sine,
  output logic [31:0] out_cosine
);

  scs_pkg::mid_t mid_in, mid_out;
  scs_pkg::res_t res_in, res_out;
  logic mid_push, mid_full, mid_pop, mid_empty;
  logic res_push, res_full;

  scs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_angle (in_angle),
    .out_push (mid_push),
    .out_full (mid_full),
    .out_data (mid_in)
  );

  scs_queue #(.W($bits(scs_pkg::mid_t)), .DEPTH(4)) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push),
    .full  (mid_full),
    .din   (mid_in),
    .pop   (mid_pop),
    .empty (mid_empty),
    .dout  (mid_out)
  );

  scs_series #(.TERMS(SERIES_TERMS)) u_series (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_empty (mid_empty),
    .in_pop   (mid_pop),
    .in_data  (mid_out),
    .out_push (res_push),
    .out_full (res_full),
    .out_data (res_in)
  );

  scs_queue #(.W($bits(scs_pkg::res_t)), .DEPTH(4)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .full  (res_full),
    .din   (res_in),
    .pop   (out_pop),
    .empty (out_empty),
    .dout  (res_out)
  );

  assign out_sine   = res_out.sine;
  assign out_cosine = res_out.cosine;

`ifndef NO_ASSERTIONS
  a_reset_empty : assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");
  a_sine_range : assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> ($signed(out_sine) <= 32'sh4000_0000 &&
                    $signed(out_sine) >= -32'sh4000_0000))
    else $error("sine beyond unit range");
  a_cosine_range : assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> ($signed(out_cosine) <= 32'sh4000_0000 &&
                    $signed(out_cosine) >= -32'sh4000_0000))
    else $error("cosine beyond unit range");
  a_mid_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
    (mid_full && !mid_pop) |=> !mid_empty)
    else $error("middle queue lost entries while full");
`endif

endmodule
